FILE: src/uricsplit_pkg.sv
// Shared types and constants for the URI component splitter.
// Holds delimiter codes, result field widths and the packed result layout.
// No dependencies.
package uricsplit_pkg;

	// Delimiter characters
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_QUEST = 8'h3F;
	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Result field widths
	localparam int OFF_W = 10;
	localparam int LEN_W = 11;

	// Number of leading or post-colon slashes that open an authority
	localparam logic [1:0] AUTH_SLASHES = 2'd2;

	// Result layout, first field in the lowest bits
	typedef struct packed {
		logic [5:0]       pad;
		logic             overflow;
		logic [LEN_W-1:0] fragment_length;
		logic [OFF_W-1:0] fragment_offset;
		logic [LEN_W-1:0] query_length;
		logic [OFF_W-1:0] query_offset;
		logic [LEN_W-1:0] path_length;
		logic [OFF_W-1:0] path_offset;
		logic [LEN_W-1:0] authority_length;
		logic [OFF_W-1:0] authority_offset;
		logic [LEN_W-1:0] scheme_length;
		logic [OFF_W-1:0] scheme_offset;
	} uricsplit_result_t;

	localparam int M_TDATA_W = $bits(uricsplit_result_t);

endpackage

FILE: src/uri_component_splitter_core.sv
// URI component splitter top level: byte stream in, one component map per URI out.
// Depends on uricsplit_pkg for delimiter codes and the result layout.
//
// Takes one URI byte per clock on the slave stream (tlast marks the final byte)
// and returns, for every URI, one transaction with offset and length of the
// scheme, authority, path, query and fragment plus an overflow flag. Bytes are
// accepted every cycle unless a final byte waits in the input register; the
// result passes through the snapshot into the output register. The pipeline is
// input register, per-byte scan register stage that snapshots the scan on the
// final byte, and the result register; only a final byte can wait, and only
// while an earlier result still occupies both the snapshot and the output
// register. Bytes beyond MAX_URI_LENGTH are dropped and reported through overflow.
module uri_component_splitter_core #(
	parameter int MAX_URI_LENGTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_tdata: [7:0] char_byte
	input  logic [7:0]                       s_tdata,
	input  logic                             s_tlast,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// m_tdata: [9:0] scheme_offset, [20:10] scheme_length, [30:21] authority_offset,
	// [41:31] authority_length, [51:42] path_offset, [62:52] path_length,
	// [72:63] query_offset, [83:73] query_length, [93:84] fragment_offset,
	// [104:94] fragment_length, [105] overflow, [111:106] zero
	output logic [uricsplit_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready
);
	import uricsplit_pkg::*;

	localparam int PW = $clog2(MAX_URI_LENGTH + 1);
	localparam int SW = PW + 2;
	localparam int EW = (SW > LEN_W) ? SW : LEN_W;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_URI_LENGTH);

	// Span of start..end within a URI of ln bytes: {length, offset}
	function automatic logic [LEN_W+OFF_W-1:0] span(
		input logic [EW-1:0] st,
		input logic [EW-1:0] en,
		input logic [EW-1:0] ln
	);
		logic [EW-1:0] n;
		begin
			n = (en < st) ? (ln - st) : (en - st);
			if (st >= ln || n == '0) begin
				return '0;
			end
			return {n[LEN_W-1:0], st[OFF_W-1:0]};
		end
	endfunction

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Scan state
	logic [PW-1:0] position_q;
	logic [PW-1:0] colon_pos_q, question_pos_q, hash_pos_q;
	logic          colon_seen_q, question_seen_q, hash_seen_q;
	logic [1:0]    lead_slashes_q, post_colon_slashes_q;
	logic [PW-1:0] slash_lead_q, slash_colon_q;
	logic          slash_lead_v_q, slash_colon_v_q;
	logic          dropped_q;

	// Next scan state
	logic [PW-1:0] position_d;
	logic [PW-1:0] colon_pos_d, question_pos_d, hash_pos_d;
	logic          colon_seen_d, question_seen_d, hash_seen_d;
	logic [1:0]    lead_slashes_d, post_colon_slashes_d;
	logic [PW-1:0] slash_lead_d, slash_colon_d;
	logic          slash_lead_v_d, slash_colon_v_d;
	logic          dropped_d;
	logic [PW-1:0] colon_dist;
	logic          keep;

	// Snapshot of the scan at the final byte
	logic          valid_s2;
	logic [PW-1:0] len_s2;
	logic [PW-1:0] colon_pos_s2, question_pos_s2, hash_pos_s2;
	logic          colon_seen_s2, question_seen_s2, hash_seen_s2;
	logic [1:0]    lead_slashes_s2, post_colon_slashes_s2;
	logic [PW-1:0] slash_lead_s2, slash_colon_s2;
	logic          slash_lead_v_s2, slash_colon_v_s2;
	logic          dropped_s2;

	// Output register
	uricsplit_result_t result_q;
	logic              out_valid_q;

	// Flow control
	logic out_ready, s2_ready, s1_go, s1_done, s1_final;

	assign out_ready = !out_valid_q || m_tready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_go     = !last_s1 || s2_ready;
	assign s1_done   = valid_s1 && s1_go;
	assign s1_final  = s1_done && last_s1;
	assign s_tready  = !valid_s1 || s1_go;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Scan one byte: first delimiters and slash runs
	always_comb begin
		keep                 = position_q < MAX_POS;
		colon_dist           = position_q - colon_pos_q;
		position_d           = position_q;
		colon_pos_d          = colon_pos_q;
		colon_seen_d         = colon_seen_q;
		question_pos_d       = question_pos_q;
		question_seen_d      = question_seen_q;
		hash_pos_d           = hash_pos_q;
		hash_seen_d          = hash_seen_q;
		lead_slashes_d       = lead_slashes_q;
		post_colon_slashes_d = post_colon_slashes_q;
		slash_lead_d         = slash_lead_q;
		slash_lead_v_d       = slash_lead_v_q;
		slash_colon_d        = slash_colon_q;
		slash_colon_v_d      = slash_colon_v_q;
		dropped_d            = dropped_q;
		if (!keep) begin
			dropped_d = 1'b1;
		end else begin
			position_d = position_q + 1'b1;
			if (byte_s1 == CHAR_COLON && !colon_seen_q) begin
				colon_seen_d = 1'b1;
				colon_pos_d  = position_q;
			end
			if (byte_s1 == CHAR_QUEST && !question_seen_q) begin
				question_seen_d = 1'b1;
				question_pos_d  = position_q;
			end
			if (byte_s1 == CHAR_HASH && !hash_seen_q) begin
				hash_seen_d = 1'b1;
				hash_pos_d  = position_q;
			end
			if (byte_s1 == CHAR_SLASH) begin
				if (position_q < PW'(2)) begin
					if (lead_slashes_q == position_q[1:0]) begin
						lead_slashes_d = lead_slashes_q + 2'd1;
					end
				end else if (!slash_lead_v_q) begin
					slash_lead_v_d = 1'b1;
					slash_lead_d   = position_q;
				end
				if (colon_seen_q && position_q > colon_pos_q) begin
					if (colon_dist <= PW'(2)) begin
						if (post_colon_slashes_q == colon_dist[1:0] - 2'd1) begin
							post_colon_slashes_d = post_colon_slashes_q + 2'd1;
						end
					end else if (!slash_colon_v_q) begin
						slash_colon_v_d = 1'b1;
						slash_colon_d   = position_q;
					end
				end
			end
		end
	end

	// Advance the scan state; clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q           <= '0;
			colon_pos_q          <= '0;
			colon_seen_q         <= 1'b0;
			question_pos_q       <= '0;
			question_seen_q      <= 1'b0;
			hash_pos_q           <= '0;
			hash_seen_q          <= 1'b0;
			lead_slashes_q       <= '0;
			post_colon_slashes_q <= '0;
			slash_lead_q         <= '0;
			slash_lead_v_q       <= 1'b0;
			slash_colon_q        <= '0;
			slash_colon_v_q      <= 1'b0;
			dropped_q            <= 1'b0;
		end else if (s1_final) begin
			position_q           <= '0;
			colon_pos_q          <= '0;
			colon_seen_q         <= 1'b0;
			question_pos_q       <= '0;
			question_seen_q      <= 1'b0;
			hash_pos_q           <= '0;
			hash_seen_q          <= 1'b0;
			lead_slashes_q       <= '0;
			post_colon_slashes_q <= '0;
			slash_lead_q         <= '0;
			slash_lead_v_q       <= 1'b0;
			slash_colon_q        <= '0;
			slash_colon_v_q      <= 1'b0;
			dropped_q            <= 1'b0;
		end else if (s1_done) begin
			position_q           <= position_d;
			colon_pos_q          <= colon_pos_d;
			colon_seen_q         <= colon_seen_d;
			question_pos_q       <= question_pos_d;
			question_seen_q      <= question_seen_d;
			hash_pos_q           <= hash_pos_d;
			hash_seen_q          <= hash_seen_d;
			lead_slashes_q       <= lead_slashes_d;
			post_colon_slashes_q <= post_colon_slashes_d;
			slash_lead_q         <= slash_lead_d;
			slash_lead_v_q       <= slash_lead_v_d;
			slash_colon_q        <= slash_colon_d;
			slash_colon_v_q      <= slash_colon_v_d;
			dropped_q            <= dropped_d;
		end
	end

	// Hold the snapshot until the output register takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_final) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_final) begin
			len_s2                <= position_d;
			colon_pos_s2          <= colon_pos_d;
			colon_seen_s2         <= colon_seen_d;
			question_pos_s2       <= question_pos_d;
			question_seen_s2      <= question_seen_d;
			hash_pos_s2           <= hash_pos_d;
			hash_seen_s2          <= hash_seen_d;
			lead_slashes_s2       <= lead_slashes_d;
			post_colon_slashes_s2 <= post_colon_slashes_d;
			slash_lead_s2         <= slash_lead_d;
			slash_lead_v_s2       <= slash_lead_v_d;
			slash_colon_s2        <= slash_colon_d;
			slash_colon_v_s2      <= slash_colon_v_d;
			dropped_s2            <= dropped_d;
		end
	end

	// Resolve component boundaries from the snapshot
	logic [EW-1:0]     len_e, colon_e, quest_e, hash_e, se, a_start, a_end, ps, p_end, q_end;
	logic              auth, ps_valid, sv;
	uricsplit_result_t result_d;

	always_comb begin
		len_e    = EW'(len_s2);
		colon_e  = EW'(colon_pos_s2);
		quest_e  = EW'(question_pos_s2);
		hash_e   = EW'(hash_pos_s2);
		result_d = '0;
		if (colon_seen_s2) begin
			{result_d.scheme_length, result_d.scheme_offset} = span('0, colon_e, len_e);
			se   = colon_e + EW'(1);
			auth = post_colon_slashes_s2 == AUTH_SLASHES;
			sv   = slash_colon_v_s2;
			ps   = EW'(slash_colon_s2);
		end else begin
			se   = '0;
			auth = lead_slashes_s2 == AUTH_SLASHES;
			sv   = slash_lead_v_s2;
			ps   = EW'(slash_lead_s2);
		end
		a_start = se + EW'(2);
		if (sv) begin
			a_end = ps;
		end else if (question_seen_s2) begin
			a_end = quest_e;
		end else if (hash_seen_s2) begin
			a_end = hash_e;
		end else begin
			a_end = len_e;
		end
		if (auth) begin
			{result_d.authority_length, result_d.authority_offset} =
				span(a_start, a_end, len_e);
			ps_valid = sv;
		end else begin
			ps_valid = 1'b1;
			ps       = se;
		end
		if (question_seen_s2) begin
			p_end = quest_e;
		end else if (hash_seen_s2) begin
			p_end = hash_e;
		end else begin
			p_end = len_e;
		end
		if (ps_valid) begin
			{result_d.path_length, result_d.path_offset} = span(ps, p_end, len_e);
		end
		q_end = hash_seen_s2 ? hash_e : len_e;
		if (question_seen_s2) begin
			{result_d.query_length, result_d.query_offset} =
				span(quest_e + EW'(1), q_end, len_e);
		end
		if (hash_seen_s2) begin
			{result_d.fragment_length, result_d.fragment_offset} =
				span(hash_e + EW'(1), len_e, len_e);
		end
		result_d.overflow = dropped_s2;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			result_q <= result_d;
		end
	end

	assign m_tdata  = result_q;
	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	// Kept byte count never passes the limit
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		position_q <= MAX_POS)
		else $error("position beyond maximum length");

	// A dropped byte only happens with the kept byte count at the limit
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> position_q == MAX_POS)
		else $error("overflow flagged below maximum length");

	// The final byte clears the scan for the next URI
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_final |=> (position_q == '0 && !colon_seen_q && !dropped_q && valid_s2))
		else $error("scan state not cleared after final byte");

	// A waiting snapshot is not lost while the output is blocked
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(len_s2)))
		else $error("snapshot changed while output stalled");
`endif

endmodule
